// ===== sv/stbl_pkg.sv =====
package stbl_pkg;

  localparam int unsigned TableDepthDef  = 4096;
  localparam int unsigned BatchLengthDef = 512;

  localparam logic [31:0] SubnetMask  = 32'hFFFF_FF00;
  localparam logic [31:0] SeedReset   = 32'h1234_5678;
  localparam logic [15:0] CapReset    = 16'd2000;
  localparam logic [15:0] RefillReset = 16'd400;

  // configuration register indexes
  localparam logic [1:0] CfgCapacity = 2'd0;
  localparam logic [1:0] CfgRefill   = 2'd1;
  localparam logic [1:0] CfgSeed     = 2'd2;

  // opcodes
  localparam logic [1:0] OpCheck  = 2'd0;
  localparam logic [1:0] OpRefill = 2'd1;
  localparam logic [1:0] OpFill   = 2'd2;

  // murmur3 constants
  localparam logic [31:0] MurC1   = 32'hcc9e_2d51;
  localparam logic [31:0] MurC2   = 32'h1b87_3593;
  localparam logic [31:0] MurC3   = 32'h85eb_ca6b;
  localparam logic [31:0] MurC4   = 32'hc2b2_ae35;
  localparam logic [31:0] MurAdd  = 32'he654_6b64;
  localparam logic [31:0] MurLen  = 32'd4;

  // mixing unit steps
  localparam logic [2:0] MixKey1 = 3'd0;
  localparam logic [2:0] MixKey2 = 3'd1;
  localparam logic [2:0] MixBody = 3'd2;
  localparam logic [2:0] MixFin1 = 3'd3;
  localparam logic [2:0] MixFin2 = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] source_address;
    logic [2:0]  batch_number;
  } item_t;

  typedef struct packed {
    logic        permitted;
    logic [11:0] bucket_index;
    logic [15:0] tokens_left;
  } result_t;

endpackage

// ===== sv/subnet_token_bucket_limiter.sv =====
// channel   direction  ports                                  transfer when
// command   in         start, busy, item_i                    start && !busy
// result    out        done_o, result_o                       done_o (one cycle)
// config    in         cfg_valid_i, cfg_ready_o, cfg_index_i,  cfg_valid_i && cfg_ready_o
//                      cfg_data_i
//
// check: five passes through the shared multiplier, then a read-modify-write
//   of the token ram
// refill: each bucket of the batch is read (StRfRd), then written back (StRfWr)
// fill: one bucket written per cycle; unused opcode: an empty result, no table access
// after reset a clearing pass writes 2000 to every bucket, busy is high
//   meanwhile; config writes are always taken
// the receiver cannot stall: each result shows for one cycle on done_o
module subnet_token_bucket_limiter import stbl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH  = TableDepthDef,
  parameter int unsigned BATCH_LENGTH = BatchLengthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  item_t       item_i,
  output logic        done_o,
  output result_t     result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned SPAN = (TABLE_DEPTH > 8 * BATCH_LENGTH) ?
                                 TABLE_DEPTH : 8 * BATCH_LENGTH;
  localparam int unsigned CW   = $clog2(SPAN + 1);

  // sequencer states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StClear = 4'd1;
  localparam logic [3:0] StFill  = 4'd2;
  localparam logic [3:0] StRfRd  = 4'd3;
  localparam logic [3:0] StRfWr  = 4'd4;
  localparam logic [3:0] StH1    = 4'd5;
  localparam logic [3:0] StH2    = 4'd6;
  localparam logic [3:0] StH3    = 4'd7;
  localparam logic [3:0] StH4    = 4'd8;
  localparam logic [3:0] StH5    = 4'd9;
  localparam logic [3:0] StCkIdx = 4'd10;
  localparam logic [3:0] StCkRd  = 4'd11;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] end_q, end_d;
  logic [31:0]   acc_q, acc_d;
  logic [31:0]   key_q, key_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          done_q, done_d;
  result_t       res_q, res_d;

  logic [15:0] cap_q;
  logic [15:0] refill_q;
  logic [31:0] seed_q;

  logic [2:0]    mix_step;
  logic [31:0]   mix_out;
  logic [31:0]   hash_fin;
  logic [31:0]   hash_idx;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;
  logic [16:0]   sum;
  logic [CW-1:0] base;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CapReset;
      refill_q <= RefillReset;
      seed_q   <= SeedReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgCapacity: cap_q    <= cfg_data_i[15:0];
        CfgRefill:   refill_q <= cfg_data_i[15:0];
        CfgSeed:     seed_q   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  stbl_mix u_mix (
    .step_i (mix_step),
    .acc_i  (acc_q),
    .key_i  (key_q),
    .seed_i (seed_q),
    .mix_o  (mix_out)
  );

  stbl_ram #(
    .WIDTH (16),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // final avalanche and table index
  assign hash_fin = acc_q ^ (acc_q >> 16);
  assign hash_idx = hash_fin & 32'(TABLE_DEPTH - 1);
  assign sum      = {1'b0, mem_rdata} + {1'b0, refill_q};
  assign base     = CW'(item_i.batch_number) * CW'(BATCH_LENGTH);
  assign busy     = (state_q != StIdle);

  always_comb begin
    case (state_q)
      StH1:    mix_step = MixKey1;
      StH2:    mix_step = MixKey2;
      StH3:    mix_step = MixBody;
      StH4:    mix_step = MixFin1;
      StH5:    mix_step = MixFin2;
      default: mix_step = MixKey1;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    end_d     = end_q;
    acc_d     = acc_q;
    key_d     = key_q;
    idx_d     = idx_q;
    done_d    = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q[AW-1:0];
    mem_wdata = cap_q;
    mem_raddr = ptr_q[AW-1:0];
    case (state_q)
      StIdle: begin
        if (start) begin
          case (item_i.opcode)
            OpCheck: begin
              key_d   = item_i.source_address & SubnetMask;
              state_d = StH1;
            end
            OpRefill: begin
              ptr_d   = base;
              end_d   = base + CW'(BATCH_LENGTH);
              state_d = StRfRd;
            end
            OpFill: begin
              ptr_d   = '0;
              state_d = StFill;
            end
            default: begin
              // unused opcode: empty result right away
              done_d = 1'b1;
              res_d  = '0;
            end
          endcase
        end
      end
      StClear, StFill: begin
        mem_we    = 1'b1;
        mem_wdata = (state_q == StClear) ? CapReset : cap_q;
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == CW'(TABLE_DEPTH - 1)) begin
          state_d = StIdle;
          if (state_q == StFill) begin
            done_d = 1'b1;
            res_d  = '0;
          end
        end
      end
      StRfRd: begin
        if (ptr_q >= end_q || ptr_q >= CW'(TABLE_DEPTH)) begin
          state_d = StIdle;
          done_d  = 1'b1;
          res_d   = '0;
        end else begin
          state_d = StRfWr;
        end
      end
      StRfWr: begin
        // saturate at capacity, which also clamps buckets above it
        mem_we    = 1'b1;
        mem_wdata = (sum >= {1'b0, cap_q}) ? cap_q : sum[15:0];
        ptr_d     = ptr_q + 1'b1;
        state_d   = StRfRd;
      end
      StH1, StH2, StH3, StH4: begin
        acc_d   = mix_out;
        state_d = state_q + 4'd1;
      end
      StH5: begin
        acc_d   = mix_out;
        state_d = StCkIdx;
      end
      StCkIdx: begin
        idx_d     = hash_idx[AW-1:0];
        mem_raddr = hash_idx[AW-1:0];
        state_d   = StCkRd;
      end
      StCkRd: begin
        mem_waddr = idx_q;
        mem_wdata = mem_rdata - 16'd1;
        mem_we    = (mem_rdata != 16'd0);
        res_d.permitted    = (mem_rdata != 16'd0);
        res_d.bucket_index = 12'(32'(idx_q));
        res_d.tokens_left  = (mem_rdata != 16'd0) ? mem_rdata - 16'd1 : 16'd0;
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      ptr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    end_q <= end_d;
    acc_q <= acc_d;
    key_q <= key_d;
    idx_q <= idx_d;
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  // the table is only written while an operation or the clearing pass runs
  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_we |-> busy)
    else $error("token ram written while idle");

  // a permit only comes out of a check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && res_q.permitted |-> $past(state_q) == StCkRd)
    else $error("permit without a check");

  // every result other than a check is all zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && $past(state_q) != StCkRd |-> res_q == '0)
    else $error("non-check result not zero");

  // a permitted check has spent a token, so fewer than the maximum remain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && res_q.permitted |-> res_q.tokens_left != 16'hFFFF)
    else $error("permitted check left a full counter");
`endif

endmodule

// ===== sv/stbl_ram.sv =====
module stbl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/stbl_mix.sv =====
module stbl_mix import stbl_pkg::*; (
  input  logic [2:0]  step_i,
  input  logic [31:0] acc_i,
  input  logic [31:0] key_i,
  input  logic [31:0] seed_i,
  output logic [31:0] mix_o
);

  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] addend;
  logic [31:0] tmp;

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    addend = '0;
    tmp    = '0;
    case (step_i)
      MixKey1: begin
        op_a = key_i;
        op_b = MurC1;
      end
      MixKey2: begin
        op_a = {acc_i[16:0], acc_i[31:17]};
        op_b = MurC2;
      end
      MixBody: begin
        tmp    = seed_i ^ acc_i;
        op_a   = {tmp[18:0], tmp[31:19]};
        op_b   = 32'd5;
        addend = MurAdd;
      end
      MixFin1: begin
        tmp  = acc_i ^ MurLen;
        op_a = tmp ^ (tmp >> 16);
        op_b = MurC3;
      end
      MixFin2: begin
        op_a = acc_i ^ (acc_i >> 13);
        op_b = MurC4;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  // shared 32x32 multiplier, low word kept
  assign mix_o = (op_a * op_b) + addend;

endmodule
